>>> hdl/assert_macros.svh
// Assertion macros shared by the steering block modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the clock and switched off while reset is active.
`define LFS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check sampled on the clock at every edge, reset included.
`define LFS_ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/lfs_pkg.sv
// Types and constants shared by the line-follow steering block.
`timescale 1ns / 1ps

package lfs_pkg;

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int DUTY_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int DELTA_W  = SAMPLE_W + 2;
    localparam int PPROD_W  = 27;
    localparam int DPROD_W  = 28;
    localparam int CORR_W   = 29;
    localparam int RAW_W    = 30;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST       = 16'd4800;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST      = 16'd1200;
    localparam logic [DUTY_W-1:0]   NOMINAL_DUTY_RST    = 16'd20000;
    localparam logic [DUTY_W-1:0]   DUTY_CEILING_RST    = 16'd40000;
    localparam logic [DUTY_W-1:0]   DUTY_FLOOR_RST      = 16'd12000;
    localparam logic [SAMPLE_W-1:0] LOST_THRESHOLD_RST  = 10'd130;
    localparam logic [SAMPLE_W-1:0] FOUND_THRESHOLD_RST = 10'd185;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_PROP_GAIN       = 3'd0,
        REG_DERIV_GAIN      = 3'd1,
        REG_NOMINAL_DUTY    = 3'd2,
        REG_DUTY_CEILING    = 3'd3,
        REG_DUTY_FLOOR      = 3'd4,
        REG_LOST_THRESHOLD  = 3'd5,
        REG_FOUND_THRESHOLD = 3'd6
    } reg_idx_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [DUTY_W-1:0]   nominal_duty;
        logic [DUTY_W-1:0]   duty_ceiling;
        logic [DUTY_W-1:0]   duty_floor;
        logic [SAMPLE_W-1:0] lost_threshold;
        logic [SAMPLE_W-1:0] found_threshold;
    } cfg_t;

    // Decision and products handed from the control stage to the mixing stage.
    typedef struct packed {
        logic                      spin;
        logic                      spin_right;
        logic signed [PPROD_W-1:0] p_prod;
        logic signed [DPROD_W-1:0] d_prod;
    } mid_t;

endpackage

>>> hdl/lfs_if.sv
// Valid/ready channel interfaces for sensor samples and motor duties.
`timescale 1ns / 1ps

interface lfs_sample_if import lfs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lfs_duty_if import lfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              recovering;

    modport source (output valid, output left_duty, output right_duty, output recovering,
                    input ready);
    modport sink   (input valid, input left_duty, input right_duty, input recovering,
                    output ready);
endinterface

>>> hdl/lfs_cfg_regs.sv
// APB-style configuration register file for the steering block.
`timescale 1ns / 1ps

module lfs_cfg_regs import lfs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Write decode; an address beyond the last register is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_PROP_GAIN:       cfg_next.prop_gain       = pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:      cfg_next.deriv_gain      = pwdata[GAIN_W-1:0];
                REG_NOMINAL_DUTY:    cfg_next.nominal_duty    = pwdata[DUTY_W-1:0];
                REG_DUTY_CEILING:    cfg_next.duty_ceiling    = pwdata[DUTY_W-1:0];
                REG_DUTY_FLOOR:      cfg_next.duty_floor      = pwdata[DUTY_W-1:0];
                REG_LOST_THRESHOLD:  cfg_next.lost_threshold  = pwdata[SAMPLE_W-1:0];
                REG_FOUND_THRESHOLD: cfg_next.found_threshold = pwdata[SAMPLE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= PROP_GAIN_RST;
            cfg_reg.deriv_gain      <= DERIV_GAIN_RST;
            cfg_reg.nominal_duty    <= NOMINAL_DUTY_RST;
            cfg_reg.duty_ceiling    <= DUTY_CEILING_RST;
            cfg_reg.duty_floor      <= DUTY_FLOOR_RST;
            cfg_reg.lost_threshold  <= LOST_THRESHOLD_RST;
            cfg_reg.found_threshold <= FOUND_THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_idx)
            REG_PROP_GAIN:       prdata = PDATA_W'(cfg_reg.prop_gain);
            REG_DERIV_GAIN:      prdata = PDATA_W'(cfg_reg.deriv_gain);
            REG_NOMINAL_DUTY:    prdata = PDATA_W'(cfg_reg.nominal_duty);
            REG_DUTY_CEILING:    prdata = PDATA_W'(cfg_reg.duty_ceiling);
            REG_DUTY_FLOOR:      prdata = PDATA_W'(cfg_reg.duty_floor);
            REG_LOST_THRESHOLD:  prdata = PDATA_W'(cfg_reg.lost_threshold);
            REG_FOUND_THRESHOLD: prdata = PDATA_W'(cfg_reg.found_threshold);
            default:             prdata = '0;
        endcase
    end

endmodule

>>> hdl/lfs_ctrl.sv
// Input register, recovery decision, steering state and gain products.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfs_ctrl import lfs_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    lfs_sample_if.sink samples,
    output logic  mid_valid,
    input  logic  mid_ready,
    output mid_t  mid
);

    // Input stage.
    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic [SAMPLE_W-1:0]        left_reg;
    logic [SAMPLE_W-1:0]        right_reg;
    // Steering state.
    logic                       lost_mode_reg;
    logic                       spin_right_reg;
    logic signed [ERR_W-1:0]    last_error_reg;
    // Middle stage.
    logic                       mid_valid_reg;
    logic                       mid_valid_next;
    mid_t                       mid_reg;

    logic                       in_adv;
    logic                       leave;
    logic                       still_lost;
    logic                       enter;
    logic                       spin;
    logic                       spin_dir;
    logic signed [ERR_W-1:0]    err;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [PPROD_W-1:0]  p_prod;
    logic signed [DPROD_W-1:0]  d_prod;

    // Pipeline flow control.
    assign in_adv        = in_valid_reg && (!mid_valid_reg || mid_ready);
    assign samples.ready = !in_valid_reg || in_adv;
    assign in_valid_next = samples.ready ? samples.valid : in_valid_reg;
    assign mid_valid_next = in_adv ? 1'b1 : (mid_ready ? 1'b0 : mid_valid_reg);
    assign mid_valid     = mid_valid_reg;
    assign mid           = mid_reg;

    // Recovery decision: leaving falls through to the enter test.
    assign leave      = lost_mode_reg && (left_reg > cfg.found_threshold)
                        && (right_reg > cfg.found_threshold);
    assign still_lost = lost_mode_reg && !leave;
    assign enter      = !still_lost && ((left_reg < cfg.lost_threshold)
                        || (right_reg < cfg.lost_threshold));
    assign spin       = still_lost || enter;
    assign spin_dir   = enter ? last_error_reg[ERR_W-1] : spin_right_reg;

    // Error terms and the two gain products.
    assign err    = $signed({1'b0, left_reg}) - $signed({1'b0, right_reg});
    assign delta  = DELTA_W'(err) - DELTA_W'(last_error_reg);
    assign p_prod = PPROD_W'($signed({1'b0, cfg.prop_gain})) * PPROD_W'(err);
    assign d_prod = DPROD_W'($signed({1'b0, cfg.deriv_gain})) * DPROD_W'(delta);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            mid_valid_reg  <= 1'b0;
            lost_mode_reg  <= 1'b0;
            spin_right_reg <= 1'b0;
            last_error_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            if (in_adv)
            begin
                lost_mode_reg  <= spin;
                spin_right_reg <= spin_dir;
                if (!spin)
                begin
                    last_error_reg <= err;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            left_reg  <= samples.left_sample;
            right_reg <= samples.right_sample;
        end
        if (in_adv)
        begin
            mid_reg.spin       <= spin;
            mid_reg.spin_right <= spin_dir;
            mid_reg.p_prod     <= p_prod;
            mid_reg.d_prod     <= d_prod;
        end
    end

    // A recovery transaction leaves the stored error untouched.
    `LFS_ASSERT_RST(a_spin_keeps_error, clk, rst_n, (in_adv && spin) |=> $stable(last_error_reg), "last error changed during recovery")
    // Entering recovery latches lost mode.
    `LFS_ASSERT_RST(a_enter_latches, clk, rst_n, (in_adv && enter) |=> lost_mode_reg, "recovery entry not latched")
    // The middle stage only fills from an advancing input stage.
    `LFS_ASSERT_RST(a_mid_source, clk, rst_n, $rose(mid_valid_reg) |-> $past(in_adv), "middle stage filled without input")

endmodule

>>> hdl/lfs_mix.sv
// Correction sum, differential duty, clamping and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfs_mix import lfs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic mid_valid,
    output logic mid_ready,
    input  mid_t mid,
    lfs_duty_if.source duties
);

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [DUTY_W-1:0]        left_duty_reg;
    logic [DUTY_W-1:0]        right_duty_reg;
    logic                     recovering_reg;
    logic [DUTY_W-1:0]        left_duty_next;
    logic [DUTY_W-1:0]        right_duty_next;

    logic                     take;
    logic signed [CORR_W-1:0] corr;
    logic signed [RAW_W-1:0]  base_s;
    logic signed [RAW_W-1:0]  max_s;
    logic signed [RAW_W-1:0]  min_s;
    logic signed [RAW_W-1:0]  left_raw;
    logic signed [RAW_W-1:0]  right_raw;
    logic signed [RAW_W-1:0]  left_clamp;
    logic signed [RAW_W-1:0]  right_clamp;

    // Output register handshake.
    assign mid_ready      = !out_valid_reg || duties.ready;
    assign take           = mid_valid && mid_ready;
    assign out_valid_next = mid_ready ? mid_valid : out_valid_reg;

    // Differential speeds from the summed correction.
    assign base_s    = RAW_W'($signed({1'b0, cfg.nominal_duty}));
    assign max_s     = RAW_W'($signed({1'b0, cfg.duty_ceiling}));
    assign min_s     = RAW_W'($signed({1'b0, cfg.duty_floor}));
    assign corr      = CORR_W'(mid.p_prod) + CORR_W'(mid.d_prod);
    assign left_raw  = base_s - RAW_W'(corr);
    assign right_raw = base_s + RAW_W'(corr);

    // Upper clamp first, then the lower clamp, which wins when inverted.
    always_comb
    begin
        left_clamp  = (left_raw > max_s) ? max_s : left_raw;
        left_clamp  = (left_clamp < min_s) ? min_s : left_clamp;
        right_clamp = (right_raw > max_s) ? max_s : right_raw;
        right_clamp = (right_clamp < min_s) ? min_s : right_clamp;
    end

    // Spin overrides the steering result.
    always_comb
    begin
        if (mid.spin)
        begin
            left_duty_next  = mid.spin_right ? cfg.duty_ceiling : '0;
            right_duty_next = mid.spin_right ? '0 : cfg.duty_ceiling;
        end
        else
        begin
            left_duty_next  = left_clamp[DUTY_W-1:0];
            right_duty_next = right_clamp[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_duty_reg  <= left_duty_next;
            right_duty_reg <= right_duty_next;
            recovering_reg <= mid.spin;
        end
    end

    assign duties.valid      = out_valid_reg;
    assign duties.left_duty  = left_duty_reg;
    assign duties.right_duty = right_duty_reg;
    assign duties.recovering = recovering_reg;

    // A spin result always has one motor stopped.
    `LFS_ASSERT_RST(a_spin_one_off, clk, rst_n,
        (out_valid_reg && recovering_reg) |-> (left_duty_reg == '0 || right_duty_reg == '0),
        "spin result drives both motors")

endmodule

>>> hdl/line_follow_pd_steering.sv
// Top level of the line-follow PD differential steering block.
//
//   channel   direction  handshake                  payload
//   samples   in         valid/ready                left_sample, right_sample
//   duties    out        valid/ready                left_duty, right_duty, recovering
//   apb       in         psel/penable/pready        paddr, pwdata, prdata
//
// One transaction per clock sustained while duties.ready stays high; after the accepting edge
// the result passes the input, product and result registers in that order.
// The gain products are registered in the product stage and the clamped sum in the result register.
// Reset clears the pipeline valids, the recovery state and the stored error,
// and loads the configuration defaults.
// A stall on the result side fills the three stages before samples.ready drops.
`timescale 1ns / 1ps

module line_follow_pd_steering import lfs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    lfs_sample_if.sink         samples,
    lfs_duty_if.source         duties,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t cfg;
    mid_t mid;
    logic mid_valid;
    logic mid_ready;

    // Configuration registers.
    lfs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decision and products.
    lfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .samples   (samples),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid)
    );

    // Sum, clamp and result register.
    lfs_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .duties    (duties)
    );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the line-follow PD steering block with random handshake gaps.
`timescale 1ns / 1ps

module tb;
    import lfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    // One motor duty transaction as the block should produce it.
    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              recovering;
    } duty_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lfs_sample_if samples_ch();
    lfs_duty_if   duties_ch();

    line_follow_pd_steering dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .duties  (duties_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // Steering model state and its copy of the registers.
    cfg_t                    steer_cfg;
    logic                    lost_latched;
    logic                    spin_to_right;
    logic signed [ERR_W-1:0] prev_error;

    duty_t duty_expect[$];
    duty_t duty_want;

    int  items_sent = 0;
    int  results_checked = 0;
    int  spins_seen = 0;
    int  cfg_writes = 0;
    int  fail_count = 0;
    int  sink_hold = 0;
    bit  no_gaps = 1'b0;

    // Register and state values after reset.
    task automatic reset_model();
        steer_cfg.prop_gain       = 16'd4800;
        steer_cfg.deriv_gain      = 16'd1200;
        steer_cfg.nominal_duty    = 16'd20000;
        steer_cfg.duty_ceiling    = 16'd40000;
        steer_cfg.duty_floor      = 16'd12000;
        steer_cfg.lost_threshold  = 10'd130;
        steer_cfg.found_threshold = 10'd185;
        lost_latched  = 1'b0;
        spin_to_right = 1'b0;
        prev_error    = '0;
    endtask

    // Upper clamp first, then the lower one, so an inverted pair yields the floor.
    function automatic logic [DUTY_W-1:0] clamp_duty(input longint v);
        longint c;
        c = v;
        if (c > longint'(steer_cfg.duty_ceiling)) c = longint'(steer_cfg.duty_ceiling);
        if (c < longint'(steer_cfg.duty_floor)) c = longint'(steer_cfg.duty_floor);
        return c[DUTY_W-1:0];
    endfunction

    // Computes the duty pair for one sample pair and advances the model state.
    function automatic duty_t steer_predict(input logic [SAMPLE_W-1:0] l,
                                            input logic [SAMPLE_W-1:0] r);
        duty_t                   d;
        logic signed [ERR_W-1:0] err;
        longint                  corr;
        logic                    spin;
        spin = 1'b0;
        if (lost_latched) begin
            if (l > steer_cfg.found_threshold && r > steer_cfg.found_threshold)
                lost_latched = 1'b0;
            else
                spin = 1'b1;
        end
        if (!spin && (l < steer_cfg.lost_threshold || r < steer_cfg.lost_threshold)) begin
            lost_latched  = 1'b1;
            spin_to_right = (prev_error < 0);
            spin          = 1'b1;
        end
        if (spin) begin
            d.left_duty  = spin_to_right ? steer_cfg.duty_ceiling : '0;
            d.right_duty = spin_to_right ? '0 : steer_cfg.duty_ceiling;
            d.recovering = 1'b1;
        end else begin
            err  = $signed({1'b0, l}) - $signed({1'b0, r});
            corr = longint'(steer_cfg.prop_gain) * longint'(err)
                 + longint'(steer_cfg.deriv_gain) * (longint'(err) - longint'(prev_error));
            d.left_duty  = clamp_duty(longint'(steer_cfg.nominal_duty) - corr);
            d.right_duty = clamp_duty(longint'(steer_cfg.nominal_duty) + corr);
            d.recovering = 1'b0;
            prev_error   = err;
        end
        return d;
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SAMPLE_W-1:0] fit_sample(input int v);
        if (v < 0) return '0;
        if (v > 1023) return 10'd1023;
        return v[SAMPLE_W-1:0];
    endfunction

    // Sends one sample pair and records its expected duties once accepted.
    task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
        int gap;
        gap = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0) begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid        <= 1'b1;
        samples_ch.left_sample  <= l;
        samples_ch.right_sample <= r;
        do @(posedge clk); while (!samples_ch.ready);
        duty_expect.push_back(steer_predict(l, r));
        items_sent++;
    endtask

    // Stops sending and waits until every expected duty transaction has arrived.
    task automatic drain_duties();
        samples_ch.valid <= 1'b0;
        do @(posedge clk); while (duty_expect.size() != 0);
    endtask

    // APB write; the bus is left selected so back-to-back writes need no extra edge.
    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_PROP_GAIN:       steer_cfg.prop_gain       = value[GAIN_W-1:0];
            REG_DERIV_GAIN:      steer_cfg.deriv_gain      = value[GAIN_W-1:0];
            REG_NOMINAL_DUTY:    steer_cfg.nominal_duty    = value[DUTY_W-1:0];
            REG_DUTY_CEILING:    steer_cfg.duty_ceiling    = value[DUTY_W-1:0];
            REG_DUTY_FLOOR:      steer_cfg.duty_floor      = value[DUTY_W-1:0];
            REG_LOST_THRESHOLD:  steer_cfg.lost_threshold  = value[SAMPLE_W-1:0];
            REG_FOUND_THRESHOLD: steer_cfg.found_threshold = value[SAMPLE_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Sometimes sets bits above the register width; they must be dropped.
    function automatic logic [PDATA_W-1:0] with_junk(input logic [PDATA_W-1:0] v,
                                                      input int w);
        if ($urandom_range(0, 3) == 0)
            return v | (PDATA_W'($urandom) << w);
        return v;
    endfunction

    // Loads a whole register set while the block is idle.
    task automatic set_config(input cfg_t c);
        drain_duties();
        write_reg(REG_PROP_GAIN,       with_junk(PDATA_W'(c.prop_gain), GAIN_W));
        write_reg(REG_DERIV_GAIN,      with_junk(PDATA_W'(c.deriv_gain), GAIN_W));
        write_reg(REG_NOMINAL_DUTY,    with_junk(PDATA_W'(c.nominal_duty), DUTY_W));
        write_reg(REG_DUTY_CEILING,    with_junk(PDATA_W'(c.duty_ceiling), DUTY_W));
        write_reg(REG_DUTY_FLOOR,      with_junk(PDATA_W'(c.duty_floor), DUTY_W));
        write_reg(REG_LOST_THRESHOLD,  with_junk(PDATA_W'(c.lost_threshold), SAMPLE_W));
        write_reg(REG_FOUND_THRESHOLD, with_junk(PDATA_W'(c.found_threshold), SAMPLE_W));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return GAIN_W'($urandom_range(0, 200));
            3:       return GAIN_W'($urandom_range(0, 8000));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Random register set; clamps are mostly ordered and thresholds mostly sane.
    function automatic cfg_t rand_cfg();
        cfg_t c;
        int   pick;
        c.prop_gain    = rand_gain();
        c.deriv_gain   = rand_gain();
        c.nominal_duty = DUTY_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            c.duty_ceiling = 16'hFFFF;
            c.duty_floor   = '0;
        end else begin
            c.duty_ceiling = DUTY_W'($urandom);
            c.duty_floor   = (pick < 8) ? DUTY_W'($urandom_range(0, c.duty_ceiling))
                                        : DUTY_W'($urandom);
        end
        if ($urandom_range(0, 4) != 0) begin
            c.lost_threshold  = SAMPLE_W'($urandom_range(0, 600));
            c.found_threshold = SAMPLE_W'($urandom_range(c.lost_threshold, 1023));
        end else begin
            c.lost_threshold  = SAMPLE_W'($urandom);
            c.found_threshold = SAMPLE_W'($urandom);
        end
        return c;
    endfunction

    // Mostly on-line pairs with a random error, plus line loss, threshold edges and noise.
    task automatic pick_samples(output logic [SAMPLE_W-1:0] l, output logic [SAMPLE_W-1:0] r);
        int mode;
        int on_lo;
        int t;
        logic [SAMPLE_W-1:0] low;
        on_lo = (steer_cfg.found_threshold == 10'h3FF) ? 1023
              : int'(steer_cfg.found_threshold) + 1;
        mode = $urandom_range(0, 99);
        if (mode < 50) begin
            l = SAMPLE_W'($urandom_range(1023, on_lo));
            if ($urandom_range(0, 1) == 1)
                r = SAMPLE_W'($urandom_range(1023, on_lo));
            else
                r = fit_sample(int'(l) + int'($urandom_range(0, 40)) - 20);
        end else if (mode < 65) begin
            low = (steer_cfg.lost_threshold == 0) ? '0
                : SAMPLE_W'($urandom_range(0, int'(steer_cfg.lost_threshold) - 1));
            if ($urandom_range(0, 1) == 1) begin
                l = low;
                r = SAMPLE_W'($urandom);
            end else begin
                l = SAMPLE_W'($urandom);
                r = low;
            end
        end else if (mode < 80) begin
            t = ($urandom_range(0, 1) == 1) ? int'(steer_cfg.lost_threshold)
                                            : int'(steer_cfg.found_threshold);
            l = fit_sample(t + int'($urandom_range(0, 4)) - 2);
            r = fit_sample(t + int'($urandom_range(0, 4)) - 2);
        end else begin
            l = SAMPLE_W'($urandom);
            r = SAMPLE_W'($urandom);
        end
    endtask

    // Reset configuration: centered line, both clamps, full-scale errors.
    task automatic test_reset_defaults();
        send_pair(10'd512, 10'd512);
        send_pair(10'd1023, 10'd130);
        send_pair(10'd130, 10'd1023);
        send_pair(10'd1023, 10'd1023);
    endtask

    // Entering, holding and leaving the recovery spin in both directions.
    task automatic test_recovery();
        cfg_t c;
        send_pair(10'd600, 10'd400);
        send_pair(10'd129, 10'd900);
        send_pair(10'd1023, 10'd185);
        send_pair(10'd0, 10'd0);
        send_pair(10'd186, 10'd186);
        send_pair(10'd300, 10'd500);
        send_pair(10'd500, 10'd129);
        send_pair(10'd1023, 10'd1023);
        // Enter threshold above the exit one: leaving and re-entering in one item.
        c = steer_cfg;
        c.lost_threshold  = 10'd600;
        c.found_threshold = 10'd200;
        set_config(c);
        send_pair(10'd600, 10'd1000);
        send_pair(10'd100, 10'd100);
        send_pair(10'd700, 10'd300);
    endtask

    // Register extremes: zero and full gains, open and shut clamps, edge thresholds.
    task automatic test_config_extremes();
        cfg_t c;
        c.prop_gain       = '0;
        c.deriv_gain      = '0;
        c.nominal_duty    = 16'hFFFF;
        c.duty_ceiling    = 16'hFFFF;
        c.duty_floor      = '0;
        c.lost_threshold  = '0;
        c.found_threshold = '0;
        set_config(c);
        send_pair(10'd0, 10'd1023);
        send_pair(10'd1023, 10'd0);

        c.prop_gain    = 16'hFFFF;
        c.deriv_gain   = 16'hFFFF;
        c.nominal_duty = '0;
        set_config(c);
        send_pair(10'd1023, 10'd0);
        send_pair(10'd0, 10'd1023);

        // Inverted clamps: the lower clamp wins on both sides.
        c.prop_gain    = 16'd1;
        c.deriv_gain   = 16'd1;
        c.nominal_duty = 16'd30000;
        c.duty_ceiling = 16'd10000;
        c.duty_floor   = 16'd50000;
        set_config(c);
        send_pair(10'd700, 10'd300);

        c.duty_ceiling = '0;
        c.duty_floor   = '0;
        set_config(c);
        send_pair(10'd512, 10'd300);

        // Highest thresholds: recovery can be entered but never left.
        c.prop_gain       = 16'd10;
        c.deriv_gain      = 16'd10;
        c.nominal_duty    = 16'd20000;
        c.duty_ceiling    = 16'd30000;
        c.duty_floor      = 16'd1000;
        c.lost_threshold  = 10'h3FF;
        c.found_threshold = 10'h3FF;
        set_config(c);
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd1022, 10'd1023);
        send_pair(10'd1023, 10'd1023);
    endtask

    // Random phases, each under a fresh register set, with one gap-free stretch.
    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [SAMPLE_W-1:0] l;
        logic [SAMPLE_W-1:0] r;
        for (int p = 0; p < phases; p++) begin
            set_config(rand_cfg());
            for (int i = 0; i < per_phase; i++) begin
                no_gaps = (i >= per_phase / 3) && (i < per_phase / 3 + 20);
                pick_samples(l, r);
                send_pair(l, r);
            end
            no_gaps = 1'b0;
        end
    endtask

    // Result side: random back-pressure.
    always @(posedge clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            duties_ch.ready <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
            sink_hold = idle_len() - 1;
            duties_ch.ready <= 1'b0;
        end else begin
            duties_ch.ready <= 1'b1;
        end
    end

    // Compares each duty transaction with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && duties_ch.valid && duties_ch.ready) begin
            if (duty_expect.size() == 0) begin
                $error("duty transaction with nothing expected: left %0d right %0d rec %0b",
                       duties_ch.left_duty, duties_ch.right_duty, duties_ch.recovering);
                fail_count++;
            end else begin
                duty_want = duty_expect.pop_front();
                results_checked++;
                if (duty_want.recovering) spins_seen++;
                if (duties_ch.left_duty !== duty_want.left_duty) begin
                    $error("left_duty: expected %0d, actual %0d",
                           duty_want.left_duty, duties_ch.left_duty);
                    fail_count++;
                end
                if (duties_ch.right_duty !== duty_want.right_duty) begin
                    $error("right_duty: expected %0d, actual %0d",
                           duty_want.right_duty, duties_ch.right_duty);
                    fail_count++;
                end
                if (duties_ch.recovering !== duty_want.recovering) begin
                    $error("recovering: expected %0b, actual %0b",
                           duty_want.recovering, duties_ch.recovering);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction happens for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((samples_ch.valid && samples_ch.ready) || (duties_ch.valid && duties_ch.ready)
                || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Test sequence.
    initial begin
        samples_ch.valid        = 1'b0;
        samples_ch.left_sample  = '0;
        samples_ch.right_sample = '0;
        duties_ch.ready         = 1'b0;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_recovery();
        test_config_extremes();
        test_random_traffic(5, 96);

        drain_duties();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (duty_expect.size() != 0) begin
            $error("%0d duty transactions never arrived", duty_expect.size());
            fail_count++;
        end
        $display("Covered %0d sample pairs and %0d duty results, %0d of them recovery spins.",
                 items_sent, results_checked, spins_seen);
        $display("Applied %0d register writes over directed and random settings; %0d errors.",
                 cfg_writes, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
